>>> sv/tgsd_pkg.sv
// shared types, constants and helpers for the tilt gesture shot detector
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package tgsd_pkg;

  // stored axes are the negated 13-bit readings, so one more bit
  typedef logic signed [13:0] axis_t;
  typedef logic [15:0]        cnt_t;
  typedef logic [1:0]         reg_idx_t;

  typedef enum logic {
    PH_IDLE  = 1'b0,
    PH_ARMED = 1'b1
  } phase_t;

  // window flags for the current sample
  typedef struct packed {
    logic level;
    logic tilt;
    logic rest;
  } win_t;

  // per-sample results of the phase controller
  typedef struct packed {
    logic armed;
    logic arm_ev;
    logic done_ev;
    logic shot;
    logic rest_ev;
  } evt_t;

  localparam reg_idx_t REG_SETTLE = 2'd0;
  localparam reg_idx_t REG_TILT   = 2'd1;
  localparam reg_idx_t REG_REST   = 2'd2;

  localparam cnt_t SETTLE_RST = 16'd1000;
  localparam cnt_t TILT_RST   = 16'd100;
  localparam cnt_t REST_RST   = 16'd3000;

  localparam axis_t LEVEL_Z_LO = 14'sd110;
  localparam axis_t LEVEL_Z_HI = 14'sd210;
  localparam axis_t LEVEL_X_LO = 14'sd200;
  localparam axis_t LEVEL_X_HI = 14'sd380;
  localparam axis_t LEVEL_Y_LO = 14'sd200;
  localparam axis_t LEVEL_Y_HI = 14'sd400;
  localparam axis_t TILT_Z_HI  = 14'sd120;
  localparam axis_t TILT_X_HI  = 14'sd200;
  localparam axis_t TILT_Y_LO  = 14'sd200;
  localparam axis_t TILT_Y_HI  = 14'sd500;
  localparam axis_t REST_X_LO  = 14'sd500;
  localparam axis_t AXIS_ZERO  = 14'sd0;

  localparam cnt_t CNT_MAX = 16'hFFFF;

  // saturating increment
  function automatic cnt_t bump(cnt_t c);
    return (c == CNT_MAX) ? c : c + 16'd1;
  endfunction

endpackage

`default_nettype wire

>>> sv/tgsd_axis_unit.sv
// axis store and window comparators
// depends on tgsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module tgsd_axis_unit (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              adv,
  input  wire              read_ok,
  input  wire signed [12:0] raw_x,
  input  wire signed [12:0] raw_y,
  input  wire signed [12:0] raw_z,
  output tgsd_pkg::win_t   win
);

  tgsd_pkg::axis_t last_x_r, last_y_r, last_z_r;
  tgsd_pkg::axis_t neg_x, neg_y, neg_z;
  tgsd_pkg::axis_t cur_x, cur_y, cur_z;

  // negation of -4096 fits in 14 bits
  assign neg_x = -$signed({raw_x[12], raw_x});
  assign neg_y = -$signed({raw_y[12], raw_y});
  assign neg_z = -$signed({raw_z[12], raw_z});

  // a failed read falls back on the last good sample
  assign cur_x = read_ok ? neg_x : last_x_r;
  assign cur_y = read_ok ? neg_y : last_y_r;
  assign cur_z = read_ok ? neg_z : last_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r <= tgsd_pkg::AXIS_ZERO;
      last_y_r <= tgsd_pkg::AXIS_ZERO;
      last_z_r <= tgsd_pkg::AXIS_ZERO;
    end else if (adv && read_ok) begin
      last_x_r <= neg_x;
      last_y_r <= neg_y;
      last_z_r <= neg_z;
    end
  end

  always_comb begin
    win.level = (cur_z > tgsd_pkg::LEVEL_Z_LO) && (cur_z < tgsd_pkg::LEVEL_Z_HI) &&
                (cur_x > tgsd_pkg::LEVEL_X_LO) && (cur_x < tgsd_pkg::LEVEL_X_HI) &&
                (cur_y > tgsd_pkg::LEVEL_Y_LO) && (cur_y < tgsd_pkg::LEVEL_Y_HI);
    win.tilt  = (cur_z < tgsd_pkg::TILT_Z_HI) && (cur_x < tgsd_pkg::TILT_X_HI) &&
                (cur_y > tgsd_pkg::TILT_Y_LO) && (cur_y < tgsd_pkg::TILT_Y_HI);
    win.rest  = (cur_z < tgsd_pkg::AXIS_ZERO) || (cur_x > tgsd_pkg::REST_X_LO);
  end

endmodule

`default_nettype wire

>>> sv/tgsd_phase_ctrl.sv
// phase state machine with window and rest counters and the tap latch
// depends on tgsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module tgsd_phase_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 adv,
  input  wire tgsd_pkg::win_t win,
  input  wire                 read_ok,
  input  wire                 tap_seen,
  input  wire                 charging,
  input  wire tgsd_pkg::cnt_t settle_limit,
  input  wire tgsd_pkg::cnt_t tilt_limit,
  input  wire tgsd_pkg::cnt_t rest_limit,
  output tgsd_pkg::evt_t      evt
);

  tgsd_pkg::phase_t phase_r, phase_nxt;
  tgsd_pkg::cnt_t   wc_r, wc_nxt;
  tgsd_pkg::cnt_t   rc_r, rc_nxt;
  logic             tap_r, tap_nxt;
  logic             arm_go, done_go, rest_go, shot;

  // counters, tap latch and event decisions, in step order
  always_comb begin
    tgsd_pkg::cnt_t wc;
    tgsd_pkg::cnt_t rc;
    logic           tap_v;
    logic           armed_mid;
    wc        = wc_r;
    rc        = rc_r;
    tap_v     = tap_r | (read_ok & tap_seen & (phase_r == tgsd_pkg::PH_ARMED));
    arm_go    = 1'b0;
    done_go   = 1'b0;
    rest_go   = 1'b0;
    shot      = 1'b0;
    armed_mid = 1'b0;
    if (charging) begin
      wc    = '0;
      rc    = '0;
      tap_v = 1'b0;
    end else begin
      if (phase_r == tgsd_pkg::PH_IDLE) begin
        if (win.level) begin
          wc = tgsd_pkg::bump(wc);
          if (wc > settle_limit) begin
            wc     = '0;
            rc     = '0;
            arm_go = 1'b1;
          end
        end else begin
          wc = '0;
        end
      end
      // arming in this beat lets the tilt check run right away
      armed_mid = (phase_r == tgsd_pkg::PH_ARMED) | arm_go;
      if (armed_mid) begin
        if (win.tilt) begin
          wc = tgsd_pkg::bump(wc);
          if (wc > tilt_limit) begin
            wc      = '0;
            rc      = '0;
            done_go = 1'b1;
            shot    = tap_v;
            tap_v   = 1'b0;
          end
        end else begin
          wc = '0;
        end
      end
      // rest count holds when the condition goes away
      if (win.rest) begin
        rc = tgsd_pkg::bump(rc);
        if (rc > rest_limit) begin
          rc      = '0;
          tap_v   = 1'b0;
          rest_go = 1'b1;
        end
      end
    end
    wc_nxt  = wc;
    rc_nxt  = rc;
    tap_nxt = tap_v;
  end

  always_comb begin
    if (charging || rest_go || done_go) begin
      phase_nxt = tgsd_pkg::PH_IDLE;
    end else if (arm_go) begin
      phase_nxt = tgsd_pkg::PH_ARMED;
    end else begin
      phase_nxt = phase_r;
    end
  end

  always_comb begin
    evt.armed   = (phase_nxt == tgsd_pkg::PH_ARMED);
    evt.arm_ev  = arm_go;
    evt.done_ev = done_go;
    evt.shot    = shot;
    evt.rest_ev = rest_go;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tgsd_pkg::PH_IDLE;
      wc_r    <= '0;
      rc_r    <= '0;
      tap_r   <= 1'b0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      wc_r    <= wc_nxt;
      rc_r    <= rc_nxt;
      tap_r   <= tap_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/tilt_gesture_shot_detector_top.sv
// top level of the tilt gesture shot detector: beat registers and limit registers
// depends on tgsd_pkg, tgsd_axis_unit and tgsd_phase_ctrl
//
// usage:
//   in_*  : one accelerometer sample per beat (axes, read status, tap, charging)
//   out_* : one result beat per sample, in order (phase and event flags)
//   cfg_* : write-only limit registers, for the user to write only while the block is idle
//           (not enforced); index 0 settle limit, 1 tilt limit, 2 rest limit, others ignored
// path: a sample accepted at an edge is in the input register; its result
//   is registered at the next edge where the output register is free, so the
//   result is offered from the output register until out_tready takes it
// throughput: one sample per cycle while out_tready is high; the whole update of phase, counters and
//   tap latch is one combinational pass between the input and output registers
// stall: while out_tready is low the result holds and one more sample can wait
//   in the input register; after that in_tready drops until the output moves
// reset: rst_n low clears both beat valid flags, phase idle, counters, tap latch,
//   stored axes to zero, and reloads limits to 1000 / 100 / 3000
`timescale 1ns / 1ps
`default_nettype none

module tilt_gesture_shot_detector_top (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  // raw_x[12:0], raw_y[25:13], raw_z[38:26], read_ok[39], tap_seen[40],
  // charging[41], zero fill[47:42]
  input  wire [47:0] in_tdata,
  output logic       out_tvalid,
  input  wire        out_tready,
  // data_valid[0], armed[1], armed_event[2], complete_event[3], shot_pulse[4],
  // rest_event[5], zero fill[7:6]
  output logic [7:0] out_tdata,
  input  wire        cfg_we,
  input  wire [1:0]  cfg_idx,
  input  wire [15:0] cfg_data
);

  logic [41:0]     in_data_r;
  logic            in_v_r;
  logic            out_v_r;
  logic [5:0]      out_data_r;
  logic            adv;
  tgsd_pkg::cnt_t  settle_r, tilt_r, rest_r;
  tgsd_pkg::win_t  win;
  tgsd_pkg::evt_t  evt;

  // process the held beat when the output register is free or draining
  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata[41:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {evt.rest_ev, evt.shot, evt.done_ev, evt.arm_ev, evt.armed,
                     in_data_r[39]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= tgsd_pkg::SETTLE_RST;
      tilt_r   <= tgsd_pkg::TILT_RST;
      rest_r   <= tgsd_pkg::REST_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        tgsd_pkg::REG_SETTLE: settle_r <= cfg_data;
        tgsd_pkg::REG_TILT:   tilt_r   <= cfg_data;
        tgsd_pkg::REG_REST:   rest_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  tgsd_axis_unit u_axis (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .read_ok (in_data_r[39]),
    .raw_x   (in_data_r[12:0]),
    .raw_y   (in_data_r[25:13]),
    .raw_z   (in_data_r[38:26]),
    .win     (win)
  );

  tgsd_phase_ctrl u_phase (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .win          (win),
    .read_ok      (in_data_r[39]),
    .tap_seen     (in_data_r[40]),
    .charging     (in_data_r[41]),
    .settle_limit (settle_r),
    .tilt_limit   (tilt_r),
    .rest_limit   (rest_r),
    .evt          (evt)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, out_data_r};

endmodule

`default_nettype wire
